@@ hdl/lrd_pkg.sv @@
// Shared types, widths and constants of the lidar ray direction block.
// Holds the sine series tables and the configuration register codes.
// Used by lrd_sin_pipe and lidar_ray_direction; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package lrd_pkg;

  // Binary angle resolution and fraction bits of the unit direction
  localparam int ANGLE_BITS = 16;
  localparam int FRAC_BITS  = 16;

  // Stream field widths
  localparam int IN_FIELD_W = 16;
  localparam int IN_DATA_W  = 3 * IN_FIELD_W;
  localparam int OUT_W      = 18;
  localparam int OUT_DATA_W = ((3 * OUT_W + 7) / 8) * 8;

  // Rotation registers: three Q1.16 coefficients of 18 bits per row
  localparam int COEF_W    = 18;
  localparam int COEF_FRAC = 16;
  localparam int ROT_N     = 3;
  localparam int REG_W     = ROT_N * COEF_W;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_X = 2'd0,
    CFG_ROW_Y = 2'd1,
    CFG_ROW_Z = 2'd2
  } cfg_idx_e;

  localparam logic [COEF_W-1:0] COEF_ONE  = COEF_W'(1) << COEF_FRAC;
  localparam logic [COEF_W-1:0] COEF_ZERO = '0;
  localparam logic [REG_W-1:0] ROW_X_RESET = {COEF_ONE, COEF_ZERO, COEF_ZERO};
  localparam logic [REG_W-1:0] ROW_Y_RESET = {COEF_ZERO, COEF_ONE, COEF_ZERO};
  localparam logic [REG_W-1:0] ROW_Z_RESET = {COEF_ZERO, COEF_ZERO, COEF_ONE};

  // Direction components and rotation sums
  localparam int DIR_W  = FRAC_BITS + 2;
  localparam int PROD_W = COEF_W + DIR_W;
  localparam int ACC_W  = PROD_W + 2;

  typedef logic signed [DIR_W-1:0] dir_t;

  // Sine series: angle folded into the first quadrant, radians in Q2.30
  localparam int R_W     = ANGLE_BITS - 1;
  localparam int X_W     = 31;
  localparam int X2_W    = 32;
  localparam int T_W     = 31;
  localparam int Q_W     = 32;
  localparam int DIV_W   = 9;
  localparam int RECIP_W = 32;
  localparam int REM_W   = 10;
  localparam int SIN_SH  = 30 - FRAC_BITS;

  localparam logic [R_W-1:0]  QUARTER     = R_W'(1) << (ANGLE_BITS - 2);
  localparam logic [X_W-1:0]  HALF_PI_Q30 = 31'd1686629713;
  localparam logic [T_W-1:0]  Q30_ONE     = 31'h4000_0000;

  localparam int SIN_ITERS = 8;
  // x and x^2 stages, four stages per series term, product and rounding
  localparam int SIN_LAT   = 2 + 4 * SIN_ITERS + 2;

  // Series term n = 8 down to 1: divisor 2n(2n+1), reciprocal and its shift.
  // The reciprocal is rounded down, so the quotient comes out at most one low.
  localparam logic [DIV_W-1:0] SIN_DIV [SIN_ITERS] = '{
    9'd272, 9'd210, 9'd156, 9'd110, 9'd72, 9'd42, 9'd20, 9'd6
  };
  localparam int SIN_SHIFT [SIN_ITERS] = '{40, 39, 39, 38, 38, 37, 36, 34};
  localparam logic [RECIP_W-1:0] SIN_RECIP [SIN_ITERS] = '{
    32'((64'd1 << 40) / 64'd272),
    32'((64'd1 << 39) / 64'd210),
    32'((64'd1 << 39) / 64'd156),
    32'((64'd1 << 38) / 64'd110),
    32'((64'd1 << 38) / 64'd72),
    32'((64'd1 << 37) / 64'd42),
    32'((64'd1 << 36) / 64'd20),
    32'((64'd1 << 34) / 64'd6)
  };

  // Values carried alongside each series term
  typedef struct packed {
    logic [X_W-1:0]  x;
    logic [X2_W-1:0] x2;
    logic            neg;
  } sin_ctx_t;

endpackage

`default_nettype wire

@@ hdl/lrd_sin_pipe.sv @@
// Pipelined binary-angle sine: quadrant fold, Taylor series in Q2.30, rounding.
// The pipeline advances only while en_i is high.
// Depends on lrd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lrd_sin_pipe (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic [lrd_pkg::ANGLE_BITS-1:0]    angle_i,
  output logic signed [lrd_pkg::DIR_W-1:0]  sin_o
);

  localparam int AB   = lrd_pkg::ANGLE_BITS;
  localparam int N    = lrd_pkg::SIN_ITERS;
  localparam int XP_W = lrd_pkg::R_W + lrd_pkg::X_W;
  localparam int PA_W = lrd_pkg::X2_W + lrd_pkg::T_W;
  localparam int PB_W = lrd_pkg::Q_W + lrd_pkg::RECIP_W;
  localparam int PC_W = lrd_pkg::Q_W + lrd_pkg::DIV_W;
  localparam int SQ_W = 2 * lrd_pkg::X_W;
  localparam int RS_W = 32;

  logic [1:0]                      quad;
  logic [lrd_pkg::R_W-1:0]         r_fold;
  logic [XP_W-1:0]                 x_prod;
  logic [SQ_W-1:0]                 sq_prod;
  logic [SQ_W-1:0]                 s_prod;
  logic [RS_W-1:0]                 s_sum;
  logic [lrd_pkg::DIR_W-1:0]       s_mag;

  logic [lrd_pkg::X_W-1:0]         x0_q;
  logic                            neg0_q;

  lrd_pkg::sin_ctx_t               ctx_q   [N+1];
  logic [lrd_pkg::T_W-1:0]         t_q     [N+1];

  logic [PA_W-1:0]                 prod_a  [N];
  logic [PB_W-1:0]                 prod_b  [N];
  logic [PC_W-1:0]                 prod_c  [N];
  logic [lrd_pkg::Q_W-1:0]         diff_c  [N];
  logic [lrd_pkg::Q_W-1:0]         quot_d  [N];

  logic [lrd_pkg::Q_W-1:0]         q_a_q   [N];
  lrd_pkg::sin_ctx_t               ctx_a_q [N];
  logic [lrd_pkg::Q_W-1:0]         q_b_q   [N];
  logic [lrd_pkg::Q_W-1:0]         qe_b_q  [N];
  lrd_pkg::sin_ctx_t               ctx_b_q [N];
  logic [lrd_pkg::Q_W-1:0]         qe_c_q  [N];
  logic [lrd_pkg::REM_W-1:0]       rem_c_q [N];
  lrd_pkg::sin_ctx_t               ctx_c_q [N];

  logic [lrd_pkg::X_W-1:0]         s_q;
  logic                            negs_q;
  logic signed [lrd_pkg::DIR_W-1:0] sin_q;

  // Fold into the first quadrant; odd quadrants mirror about a quarter turn
  assign quad    = angle_i[AB-1 -: 2];
  assign r_fold  = quad[0] ? (lrd_pkg::QUARTER - lrd_pkg::R_W'(angle_i[AB-3:0]))
                           : lrd_pkg::R_W'(angle_i[AB-3:0]);
  assign x_prod  = XP_W'(r_fold) * XP_W'(lrd_pkg::HALF_PI_Q30);
  assign sq_prod = SQ_W'(x0_q) * SQ_W'(x0_q);
  assign s_prod  = SQ_W'(ctx_q[N].x) * SQ_W'(t_q[N]);
  assign s_sum   = RS_W'(s_q) + (RS_W'(1) << (lrd_pkg::SIN_SH - 1));
  assign s_mag   = s_sum[RS_W-1:lrd_pkg::SIN_SH];

  // Horner form, innermost term first: t = 1 - x^2 * t / (2n(2n+1))
  always_comb begin
    for (int i = 0; i < N; i++) begin
      prod_a[i] = PA_W'(ctx_q[i].x2) * PA_W'(t_q[i]);
      prod_b[i] = PB_W'(q_a_q[i]) * PB_W'(lrd_pkg::SIN_RECIP[i]);
      prod_c[i] = PC_W'(qe_b_q[i]) * PC_W'(lrd_pkg::SIN_DIV[i]);
      diff_c[i] = q_b_q[i] - lrd_pkg::Q_W'(prod_c[i]);
      // Reciprocal estimate may be one short: bump when the remainder allows
      quot_d[i] = qe_c_q[i] +
                  lrd_pkg::Q_W'(rem_c_q[i] >= lrd_pkg::REM_W'(lrd_pkg::SIN_DIV[i]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x0_q     <= x_prod[AB-2 +: lrd_pkg::X_W];
      neg0_q   <= quad[1];
      ctx_q[0] <= '{x: x0_q, x2: sq_prod[30 +: lrd_pkg::X2_W], neg: neg0_q};
      t_q[0]   <= lrd_pkg::Q30_ONE;
      for (int i = 0; i < N; i++) begin
        q_a_q[i]    <= prod_a[i][30 +: lrd_pkg::Q_W];
        ctx_a_q[i]  <= ctx_q[i];
        q_b_q[i]    <= q_a_q[i];
        qe_b_q[i]   <= lrd_pkg::Q_W'(prod_b[i] >> lrd_pkg::SIN_SHIFT[i]);
        ctx_b_q[i]  <= ctx_a_q[i];
        qe_c_q[i]   <= qe_b_q[i];
        rem_c_q[i]  <= lrd_pkg::REM_W'(diff_c[i]);
        ctx_c_q[i]  <= ctx_b_q[i];
        t_q[i+1]    <= lrd_pkg::Q30_ONE - lrd_pkg::T_W'(quot_d[i]);
        ctx_q[i+1]  <= ctx_c_q[i];
      end
      s_q    <= s_prod[30 +: lrd_pkg::X_W];
      negs_q <= ctx_q[N].neg;
      sin_q  <= negs_q ? -$signed(s_mag) : $signed(s_mag);
    end
  end

  assign sin_o = sin_q;

endmodule

`default_nettype wire

@@ hdl/lidar_ray_direction.sv @@
// Throughput: one item per clock while the skid slot is empty; the depth comes
// from the sine unit, whose eight series terms take four stages each (multiply,
// reciprocal, remainder, correction). Stalls freeze the whole pipeline; a one-item
// skid after the output register keeps s_axis_tready a register. Reset clears all
// valid flags and loads the identity rotation; no other state is cleared.
`timescale 1ns / 1ps
`default_nettype none

module lidar_ray_direction (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Input items
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [lrd_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // sweep_angle, elevation_angle,
                                                          // azimuth_offset
  input  logic                             s_axis_tlast,  // last_laser
  // Result items
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [lrd_pkg::OUT_DATA_W-1:0]   m_axis_tdata,  // dir_x, dir_y, dir_z, zero pad
  output logic                             m_axis_tlast,  // last_ray
  // Rotation register writes
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [lrd_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [lrd_pkg::REG_W-1:0]        cfg_data_i
);

  localparam int AB   = lrd_pkg::ANGLE_BITS;
  localparam int FB   = lrd_pkg::FRAC_BITS;
  localparam int DW   = lrd_pkg::DIR_W;
  localparam int LAT  = lrd_pkg::SIN_LAT;
  localparam int N3   = lrd_pkg::ROT_N;
  localparam int CW   = lrd_pkg::COEF_W;
  localparam int PW   = lrd_pkg::PROD_W;
  localparam int AW   = lrd_pkg::ACC_W;
  localparam int OW   = lrd_pkg::OUT_W;
  localparam int FW   = lrd_pkg::IN_FIELD_W;
  localparam int RES_W = N3 * OW;

  localparam logic signed [AW-1:0] SAT_HI  = AW'((1 << (OW - 1)) - 1);
  localparam logic signed [AW-1:0] SAT_LO  = ~SAT_HI;
  localparam logic signed [DW-1:0] DIR_ONE = DW'(1) << FB;

  // Signed product to Q FRAC_BITS, rounded half away from zero
  function automatic lrd_pkg::dir_t round_dir(input logic signed [2*DW-1:0] v);
    logic [2*DW-1:0] mag;
    mag = v[2*DW-1] ? $unsigned(-v) : $unsigned(v);
    mag = (mag + ((2*DW)'(1) << (FB - 1))) >> FB;
    return v[2*DW-1] ? -$signed(DW'(mag)) : $signed(DW'(mag));
  endfunction

  // Rotation sum to Q1.16, rounded half away from zero, then saturated
  function automatic logic [OW-1:0] round_sat(input logic signed [AW-1:0] v);
    logic [AW-1:0]        mag;
    logic signed [AW-1:0] rnd;
    logic [OW-1:0]        res;
    mag = v[AW-1] ? $unsigned(-v) : $unsigned(v);
    mag = (mag + (AW'(1) << (FB - 1))) >> FB;
    rnd = v[AW-1] ? -$signed(mag) : $signed(mag);
    if (rnd > SAT_HI) begin
      res = OW'(SAT_HI);
    end else if (rnd < SAT_LO) begin
      res = OW'(SAT_LO);
    end else begin
      res = OW'(rnd);
    end
    return res;
  endfunction

  // Control
  logic                     pipe_en;
  logic                     push;
  logic                     pop;
  logic                     in_acc;
  logic                     in_v_q;
  logic [LAT-1:0]           kv_q;
  logic                     p1_v_q, p2_v_q, p3_v_q, p4_v_q, p5_v_q;
  logic                     out_valid_q, out_valid_d;
  logic                     skid_valid_q, skid_valid_d;
  logic [lrd_pkg::REG_W-1:0] row_q [N3];

  // Payload
  logic                     in_last_q;
  logic [AB-1:0]            in_h_q, in_e_q;
  logic [AB-1:0]            h_cos, e_cos;
  logic [LAT-1:0]           kl_q;
  lrd_pkg::dir_t            sin_h, cos_h, sin_e, cos_e;
  logic signed [2*DW-1:0]   prod_x_d, prod_y_d;
  logic signed [2*DW-1:0]   prod_x_q, prod_y_q;
  lrd_pkg::dir_t            sv_p1_q;
  logic                     p1_l_q, p2_l_q, p3_l_q, p4_l_q, p5_l_q;
  lrd_pkg::dir_t            dir_q  [N3];
  logic signed [CW-1:0]     coef   [N3][N3];
  logic signed [PW-1:0]     rp_d   [N3][N3];
  logic signed [PW-1:0]     rp_q   [N3][N3];
  logic signed [AW-1:0]     acc_d  [N3];
  logic signed [AW-1:0]     acc_q  [N3];
  logic [OW-1:0]            res_q  [N3];
  logic [RES_W-1:0]         res_flat;
  logic [RES_W-1:0]         out_data_q, out_data_d;
  logic                     out_last_q, out_last_d;
  logic [RES_W-1:0]         skid_data_q;
  logic                     skid_last_q;

  // Pipeline moves as a whole while the skid slot is free
  assign pipe_en       = !skid_valid_q;
  assign s_axis_tready = pipe_en;
  assign in_acc        = s_axis_tvalid && pipe_en;
  assign push          = pipe_en && p5_v_q;
  assign pop           = out_valid_q && m_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // Cosine is the sine a quarter turn on: step the quadrant bits
  assign h_cos = {in_h_q[AB-1 -: 2] + 2'd1, in_h_q[AB-3:0]};
  assign e_cos = {in_e_q[AB-1 -: 2] + 2'd1, in_e_q[AB-3:0]};

  lrd_sin_pipe u_sin_h (.clk_i(clk_i), .en_i(pipe_en), .angle_i(in_h_q), .sin_o(sin_h));
  lrd_sin_pipe u_cos_h (.clk_i(clk_i), .en_i(pipe_en), .angle_i(h_cos),  .sin_o(cos_h));
  lrd_sin_pipe u_sin_e (.clk_i(clk_i), .en_i(pipe_en), .angle_i(in_e_q), .sin_o(sin_e));
  lrd_sin_pipe u_cos_e (.clk_i(clk_i), .en_i(pipe_en), .angle_i(e_cos),  .sin_o(cos_e));

  assign prod_x_d = cos_e * cos_h;
  assign prod_y_d = cos_e * sin_h;

  always_comb begin
    for (int i = 0; i < N3; i++) begin
      for (int j = 0; j < N3; j++) begin
        coef[i][j] = $signed(row_q[i][lrd_pkg::REG_W-1-CW*j -: CW]);
        rp_d[i][j] = coef[i][j] * dir_q[j];
      end
      acc_d[i] = AW'(rp_q[i][0]) + AW'(rp_q[i][1]) + AW'(rp_q[i][2]);
    end
  end

  always_comb begin
    for (int i = 0; i < N3; i++) begin
      res_flat[OW*i +: OW] = res_q[i];
    end
  end

  // Output register with a one-item skid behind it
  always_comb begin
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    out_last_d   = out_last_q;
    skid_valid_d = skid_valid_q;
    if (skid_valid_q) begin
      if (pop) begin
        out_data_d   = skid_data_q;
        out_last_d   = skid_last_q;
        skid_valid_d = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_q || pop) begin
        out_valid_d = 1'b1;
        out_data_d  = res_flat;
        out_last_d  = p5_l_q;
      end else begin
        skid_valid_d = 1'b1;
      end
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q       <= 1'b0;
      kv_q         <= '0;
      p1_v_q       <= 1'b0;
      p2_v_q       <= 1'b0;
      p3_v_q       <= 1'b0;
      p4_v_q       <= 1'b0;
      p5_v_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
      row_q[0]     <= lrd_pkg::ROW_X_RESET;
      row_q[1]     <= lrd_pkg::ROW_Y_RESET;
      row_q[2]     <= lrd_pkg::ROW_Z_RESET;
    end else begin
      if (pipe_en) begin
        in_v_q <= in_acc;
        kv_q   <= {kv_q[LAT-2:0], in_v_q};
        p1_v_q <= kv_q[LAT-1];
        p2_v_q <= p1_v_q;
        p3_v_q <= p2_v_q;
        p4_v_q <= p3_v_q;
        p5_v_q <= p4_v_q;
      end
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
      if (cfg_valid_i) begin
        case (lrd_pkg::cfg_idx_e'(cfg_index_i))
          lrd_pkg::CFG_ROW_X: row_q[0] <= cfg_data_i;
          lrd_pkg::CFG_ROW_Y: row_q[1] <= cfg_data_i;
          lrd_pkg::CFG_ROW_Z: row_q[2] <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      // Horizontal angle wraps modulo a full turn
      in_h_q    <= AB'(s_axis_tdata[0 +: FW]) + AB'(s_axis_tdata[2*FW +: FW]);
      in_e_q    <= AB'(s_axis_tdata[FW +: FW]);
      in_last_q <= s_axis_tlast;
      kl_q      <= {kl_q[LAT-2:0], in_last_q};
      prod_x_q  <= prod_x_d;
      prod_y_q  <= prod_y_d;
      sv_p1_q   <= sin_e;
      p1_l_q    <= kl_q[LAT-1];
      dir_q[0]  <= round_dir(prod_x_q);
      dir_q[1]  <= round_dir(prod_y_q);
      dir_q[2]  <= sv_p1_q;
      p2_l_q    <= p1_l_q;
      rp_q      <= rp_d;
      p3_l_q    <= p2_l_q;
      acc_q     <= acc_d;
      p4_l_q    <= p3_l_q;
      for (int i = 0; i < N3; i++) begin
        res_q[i] <= round_sat(acc_q[i]);
      end
      p5_l_q    <= p4_l_q;
    end
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
    if (!skid_valid_q && push && out_valid_q && !pop) begin
      skid_data_q <= res_flat;
      skid_last_q <= p5_l_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = lrd_pkg::OUT_DATA_W'(out_data_q);
  assign m_axis_tlast  = out_last_q;

`ifndef ASSERT_OFF
  // The skid slot only fills behind a waiting result
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds an item while the output register is empty");

  a_skid_fill_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && !m_axis_tready && p5_v_q))
    else $error("skid filled without a stalled output");

  a_out_from_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(p5_v_q && pipe_en))
    else $error("result appeared without an item leaving the pipeline");

  a_cos_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kv_q[LAT-1] |-> (cos_e <= DIR_ONE && cos_e >= -DIR_ONE))
    else $error("cosine of elevation beyond unit magnitude");
`endif

endmodule

`default_nettype wire
